>>> src/prf_pkg.sv
`timescale 1ns / 1ps

package prf_pkg;

  localparam int TIME_W  = 32;
  localparam int LVL_W   = 10;
  localparam int TGT_W   = 11;
  localparam int HOLD_W  = 16;
  localparam int PCT_W   = 7;
  localparam int QUOT_W  = 11;
  localparam int PROD_W  = TIME_W + QUOT_W;

  localparam logic [LVL_W-1:0]  LEVEL_MAX     = 10'd1023;
  localparam logic [PCT_W-1:0]  PERCENT_MAX   = 7'd100;
  localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 16'd10;

  // register indexes on the configuration port
  localparam logic REG_RAMP_ENABLE = 1'b0;
  localparam logic REG_HOLDOFF     = 1'b1;

  // item actions
  localparam logic ACT_SET  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // drive modes
  localparam logic [1:0] DRIVE_LOW  = 2'd0;
  localparam logic [1:0] DRIVE_HIGH = 2'd1;
  localparam logic [1:0] DRIVE_PWM  = 2'd2;

  // one channel's entry in the state memory
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] last_update;
    logic [LVL_W-1:0]  start_level;
    logic [LVL_W-1:0]  current_level;
    logic [TGT_W-1:0]  target_level;
  } chan_rec_t;

  // 1024*p/100 for p <= 100: p*10486 >> 10 is exact over that range
  function automatic logic [TGT_W-1:0] target_of(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] p;
    logic [20:0]      prod;
    p    = (pct > PERCENT_MAX) ? PERCENT_MAX : pct;
    prod = 21'(p) * 21'd10486;
    return prod[20:10];
  endfunction

endpackage

>>> src/prf_mem.sv
`timescale 1ns / 1ps

module prf_mem #(
  parameter int DEPTH = 5,
  parameter int AW    = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ren,
  input  logic [AW-1:0]      raddr,
  output prf_pkg::chan_rec_t rdata,
  input  logic               wen,
  input  logic [AW-1:0]      waddr,
  input  prf_pkg::chan_rec_t wdata
);
  import prf_pkg::*;

  chan_rec_t        mem [DEPTH];
  logic [DEPTH-1:0] written;
  chan_rec_t        rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rd_q <= mem[raddr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (ren) begin
        rd_vld <= written[raddr];
      end
      if (wen) begin
        written[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

>>> src/prf_div.sv
`timescale 1ns / 1ps

module prf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [prf_pkg::PROD_W-1:0] numer,
  input  logic [prf_pkg::TIME_W-1:0] denom,
  output logic                       done,
  output logic [prf_pkg::QUOT_W-1:0] quot
);
  import prf_pkg::*;

  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dsh;
  logic [3:0]        cnt;
  logic              run;

  // restoring division, one quotient bit per cycle; quotient known to fit QUOT_W
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= numer;
        dsh  <= PROD_W'({denom, {(QUOT_W-1){1'b0}}});
        cnt  <= 4'(QUOT_W - 1);
        quot <= '0;
        run  <= 1'b1;
      end else if (run) begin
        if (rem >= dsh) begin
          rem  <= rem - dsh;
          quot <= {quot[QUOT_W-2:0], 1'b1};
        end else begin
          quot <= {quot[QUOT_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        if (cnt == 4'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 4'd1;
        end
      end
    end
  end

endmodule

>>> src/pwm_ramp_fader.sv
`timescale 1ns / 1ps

// Linear PWM fader over CHANNELS channels, one item at a time while busy is high.
// A set item does one memory read and one write back; a set for a channel out of
// range is dropped. A tick, taken only while ramp_enable is 1, walks the channels
// in order through the channel state memory: a channel at or outside its ramp ends
// goes from its read straight to the decide, and one inside a ramp adds a multiply,
// then an 11-step serial divider and its done strobe; a flush state ends the tick.
// Results appear for one cycle each on valid and cannot be stalled; each is held
// back until the next one is found, so last marks the final result of a tick.
module pwm_ramp_fader #(
  parameter int CHANNELS = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [2:0]                  channel,
  input  logic [prf_pkg::PCT_W-1:0]   percent,
  input  logic [prf_pkg::TIME_W-1:0]  period_ms,
  input  logic [prf_pkg::TIME_W-1:0]  now_ms,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [prf_pkg::HOLD_W-1:0]  cfg_data,
  output logic                        valid,
  output logic [2:0]                  channel_out,
  output logic [prf_pkg::LVL_W-1:0]   level,
  output logic [1:0]                  drive_mode,
  output logic                        last
);
  import prf_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SET, ST_READ, ST_MUL, ST_DIV, ST_DECIDE, ST_FLUSH
  } state_t;

  state_t              state;
  logic [CH_W-1:0]     ch;
  logic [PCT_W-1:0]    pct_q;
  logic [TIME_W-1:0]   period_q;
  logic [TIME_W-1:0]   now_q;
  chan_rec_t           rec;
  logic signed [11:0]  vraw;
  logic                interp;
  logic                neg;
  logic [TIME_W-1:0]   elapsed;
  logic [TIME_W-1:0]   span;
  logic [TGT_W-1:0]    absd;
  logic                pend;
  logic [CH_W-1:0]     pend_ch;
  logic [LVL_W-1:0]    pend_lv;
  logic                ramp_enable;
  logic [HOLD_W-1:0]   holdoff;

  logic                ren;
  logic [CH_W-1:0]     raddr;
  chan_rec_t           rdata;
  logic                wen;
  chan_rec_t           wdata;
  logic                div_start;
  logic                div_done;
  logic [QUOT_W-1:0]   quot;
  logic [PROD_W-1:0]   numer;

  logic                chan_ok;
  logic [CH_W-1:0]     ch_inc;
  logic signed [11:0]  s_lvl;
  logic signed [11:0]  q_s;
  logic signed [11:0]  vsum;
  logic signed [11:0]  diff;
  logic [LVL_W-1:0]    lv;
  logic                hold_ok;
  logic                upd;

  function automatic logic [1:0] mode_of(input logic [LVL_W-1:0] l);
    if (l == '0) begin
      return DRIVE_LOW;
    end else if (l == LEVEL_MAX) begin
      return DRIVE_HIGH;
    end
    return DRIVE_PWM;
  endfunction

  assign busy    = (state != ST_IDLE);
  assign chan_ok = ({29'b0, channel} < CHANNELS);
  assign ch_inc  = ch + 1'b1;

  // level for the channel being decided
  assign s_lvl   = $signed({2'b00, rec.start_level});
  assign q_s     = $signed({1'b0, quot});
  assign vsum    = interp ? (neg ? s_lvl - q_s : s_lvl + q_s) : vraw;
  assign lv      = (vsum < 0) ? '0 :
                   (vsum > $signed({2'b00, LEVEL_MAX})) ? LEVEL_MAX : vsum[LVL_W-1:0];
  assign hold_ok = ({1'b0, rec.last_update} + {17'b0, holdoff}) < {1'b0, now_q};
  assign upd     = (lv != rec.current_level) && hold_ok;

  assign diff  = $signed({1'b0, rdata.target_level}) - $signed({2'b00, rdata.start_level});
  assign numer = PROD_W'(elapsed) * PROD_W'(absd);

  always_comb begin
    ren       = 1'b0;
    raddr     = '0;
    wen       = 1'b0;
    wdata     = rec;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (action == ACT_SET) begin
          raddr = CH_W'(channel);
          ren   = start && chan_ok;
        end else begin
          ren = start && ramp_enable;
        end
      end
      ST_SET: begin
        wen                 = 1'b1;
        wdata.start_time    = now_q;
        wdata.end_time      = now_q + period_q;
        wdata.last_update   = rdata.last_update;
        wdata.start_level   = rdata.current_level;
        wdata.current_level = rdata.current_level;
        wdata.target_level  = target_of(pct_q);
      end
      ST_MUL: begin
        div_start = 1'b1;
      end
      ST_DECIDE: begin
        wen                 = upd;
        wdata.last_update   = now_q;
        wdata.current_level = lv;
        raddr               = ch_inc;
        ren                 = (ch != CH_LAST);
      end
      ST_READ, ST_DIV, ST_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_enable <= 1'b1;
      holdoff     <= HOLDOFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAMP_ENABLE: ramp_enable <= cfg_data[0];
        REG_HOLDOFF:     holdoff     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            pct_q    <= percent;
            period_q <= period_ms;
            now_q    <= now_ms;
            pend     <= 1'b0;
            if (action == ACT_SET) begin
              ch <= CH_W'(channel);
              if (chan_ok) begin
                state <= ST_SET;
              end
            end else begin
              ch <= '0;
              if (ramp_enable) begin
                state <= ST_READ;
              end
            end
          end
        end
        ST_SET: begin
          state <= ST_IDLE;
        end
        ST_READ: begin
          rec <= rdata;
          if (now_q >= rdata.end_time) begin
            vraw   <= $signed({1'b0, rdata.target_level});
            interp <= 1'b0;
            state  <= ST_DECIDE;
          end else if (now_q <= rdata.start_time) begin
            vraw   <= $signed({2'b00, rdata.current_level});
            interp <= 1'b0;
            state  <= ST_DECIDE;
          end else begin
            interp  <= 1'b1;
            elapsed <= now_q - rdata.start_time;
            span    <= rdata.end_time - rdata.start_time;
            neg     <= (diff < 0);
            absd    <= (diff < 0) ? TGT_W'(-diff) : TGT_W'(diff);
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (upd) begin
            // the previous result goes out now that another follows it
            if (pend) begin
              valid       <= 1'b1;
              channel_out <= 3'(pend_ch);
              level       <= pend_lv;
              drive_mode  <= mode_of(pend_lv);
              last        <= 1'b0;
            end
            pend    <= 1'b1;
            pend_ch <= ch;
            pend_lv <= lv;
          end
          if (ch == CH_LAST) begin
            state <= ST_FLUSH;
          end else begin
            ch    <= ch_inc;
            state <= ST_READ;
          end
        end
        ST_FLUSH: begin
          if (pend) begin
            valid       <= 1'b1;
            channel_out <= 3'(pend_ch);
            level       <= pend_lv;
            drive_mode  <= mode_of(pend_lv);
            last        <= 1'b1;
          end
          pend  <= 1'b0;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  prf_mem #(
    .DEPTH(CHANNELS),
    .AW   (CH_W)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .ren  (ren),
    .raddr(raddr),
    .rdata(rdata),
    .wen  (wen),
    .waddr(ch),
    .wdata(wdata)
  );

  prf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .numer(numer),
    .denom(span),
    .done (div_done),
    .quot (quot)
  );

endmodule
